// ===== rtl/sqd_pkg.sv =====
// Shared constants and the pipeline stage record of the signed Q16.16 divider.
// No dependencies; every other file of the divider imports this package.
`default_nettype none

package sqd_pkg;

  // Operand and result width, and the count of fraction bits.
  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;

  // Quotient bits that are kept: the integer part plus the fraction bits.
  // One cell of the chain produces one of these bits.
  localparam int unsigned QuotW    = DataW + FracBits;

  // Largest negative magnitude that still fits a signed result.
  localparam logic [DataW-1:0] MinNegMag = {1'b1, {(DataW-1){1'b0}}};

  // Everything one item carries from cell to cell.
  typedef struct packed {
    logic             vld;   // Stage holds a live item.
    logic [DataW-1:0] rem;   // Partial remainder, below the divisor unless the divisor is zero.
    logic [QuotW-1:0] word;  // Dividend bits still to consume, quotient bits below.
    logic [DataW-1:0] dvs;   // Divisor magnitude.
    logic             neg;   // Result is negative.
    logic             dz;    // Divisor was zero.
  } sqd_stage_t;

endpackage

`default_nettype wire

// ===== rtl/sqd_in_if.sv =====
// Operand channel of the signed Q16.16 divider: valid, ready and the two operands.
// Depends on sqd_pkg for the data width.
`default_nettype none

interface sqd_in_if;
  import sqd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] dividend;
  logic signed [DataW-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

`default_nettype wire

// ===== rtl/sqd_out_if.sv =====
// Result channel of the signed Q16.16 divider: valid, ready, quotient and flags.
// Depends on sqd_pkg for the data width.
`default_nettype none

interface sqd_out_if;
  import sqd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] quotient;
  logic                    divide_by_zero;
  logic                    overflow;

  modport source (output valid, output quotient, output divide_by_zero,
                  output overflow, input ready);
  modport sink   (input valid, input quotient, input divide_by_zero,
                  input overflow, output ready);

endinterface

`default_nettype wire

// ===== rtl/sqd_prep.sv =====
// Entry stage: takes operand transfers, forms magnitudes, sign and zero flag.
// Depends on sqd_pkg and sqd_in_if.
`default_nettype none

module sqd_prep
  import sqd_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        en_i,
  sqd_in_if.sink     in_i,
  output sqd_stage_t stage_o
);

  logic [DataW-1:0] mag_a;
  logic [DataW-1:0] mag_b;
  logic             vld_q;
  sqd_stage_t       pay_q;

  // The pipeline moves as one; the operand channel is ready whenever it moves.
  assign in_i.ready = en_i;

  // Two's complement magnitudes; the most negative value maps onto itself,
  // which is its exact unsigned magnitude.
  always_comb begin
    mag_a = in_i.dividend[DataW-1] ? (~$unsigned(in_i.dividend) + 1'b1)
                                   : $unsigned(in_i.dividend);
    mag_b = in_i.divisor[DataW-1]  ? (~$unsigned(in_i.divisor) + 1'b1)
                                   : $unsigned(in_i.divisor);
  end

  // Valid bit with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_i.valid;
    end
  end

  // Payload without reset. The dividend sits on top of the word, the fraction
  // bits below it start as zeros that the last cells bring down.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q.vld  <= 1'b0;
      pay_q.rem  <= '0;
      pay_q.word <= QuotW'(mag_a) << FracBits;
      pay_q.dvs  <= mag_b;
      pay_q.neg  <= in_i.dividend[DataW-1] ^ in_i.divisor[DataW-1];
      pay_q.dz   <= (mag_b == '0);
    end
  end

  always_comb begin
    stage_o     = pay_q;
    stage_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// ===== rtl/sqd_cell.sv =====
// One restoring shift-subtract step of the divider chain, registered.
// Depends on sqd_pkg.
`default_nettype none

module sqd_cell
  import sqd_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        en_i,
  input  sqd_stage_t stage_i,
  output sqd_stage_t stage_o
);

  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic             take;
  logic             vld_q;
  sqd_stage_t       pay_q;

  // Bring down the next dividend bit and try the subtraction. With a zero
  // divisor every step succeeds and the remainder simply wraps, which yields
  // the all-ones quotient.
  always_comb begin
    rem_sh = {stage_i.rem, stage_i.word[QuotW-1]};
    diff   = rem_sh - {1'b0, stage_i.dvs};
    take   = (rem_sh >= {1'b0, stage_i.dvs});
  end

  // Valid bit with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  // Payload: restored or reduced remainder, quotient bit shifted in at the bottom.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q.vld  <= 1'b0;
      pay_q.rem  <= take ? diff[DataW-1:0] : rem_sh[DataW-1:0];
      pay_q.word <= {stage_i.word[QuotW-2:0], take};
      pay_q.dvs  <= stage_i.dvs;
      pay_q.neg  <= stage_i.neg;
      pay_q.dz   <= stage_i.dz;
    end
  end

  always_comb begin
    stage_o     = pay_q;
    stage_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// ===== rtl/sqd_post.sv =====
// Exit stage: applies the sign, detects overflow, and holds results in an
// output register backed by one skid register. Depends on sqd_pkg and sqd_out_if.
`default_nettype none

module sqd_post
  import sqd_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  sqd_stage_t stage_i,
  output logic       en_o,
  sqd_out_if.source  out_o
);

  logic [DataW-1:0] res_quot;
  logic             res_ovf;
  logic             push;
  logic             stall;

  logic             out_vld_q;
  logic [DataW-1:0] out_quot_q;
  logic             out_dz_q;
  logic             out_ovf_q;

  logic             skid_vld_q;
  logic [DataW-1:0] skid_quot_q;
  logic             skid_dz_q;
  logic             skid_ovf_q;

  // Signed result, wrapped to the data width, and the fit check on the
  // full kept magnitude.
  always_comb begin
    res_quot = stage_i.neg ? (~stage_i.word[DataW-1:0] + 1'b1) : stage_i.word[DataW-1:0];
    res_ovf  = stage_i.neg ? (stage_i.word > QuotW'(MinNegMag))
                           : (stage_i.word > QuotW'(MinNegMag - 1'b1));
  end

  // The chain runs while the skid register is free.
  assign en_o  = ~skid_vld_q;
  assign push  = en_o & stage_i.vld;
  assign stall = out_vld_q & ~out_o.ready;

  // Control: output and skid valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (stall) begin
      if (push) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= push;
    end
  end

  // Payload moves along the same decisions.
  always_ff @(posedge clk_i) begin
    if (stall) begin
      if (push) begin
        skid_quot_q <= res_quot;
        skid_dz_q   <= stage_i.dz;
        skid_ovf_q  <= res_ovf;
      end
    end else if (skid_vld_q) begin
      out_quot_q <= skid_quot_q;
      out_dz_q   <= skid_dz_q;
      out_ovf_q  <= skid_ovf_q;
    end else if (push) begin
      out_quot_q <= res_quot;
      out_dz_q   <= stage_i.dz;
      out_ovf_q  <= res_ovf;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.quotient       = $signed(out_quot_q);
  assign out_o.divide_by_zero = out_dz_q;
  assign out_o.overflow       = out_ovf_q;

  // The skid register only ever fills behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register is empty");

  // A result arriving at a stalled output must be caught by the skid register.
  a_skid_catches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stall && push) |=> skid_vld_q)
    else $error("result lost at a stalled output");

  // A zero divisor always reports overflow as well.
  a_dz_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_dz_q) |-> out_ovf_q)
    else $error("divide by zero without overflow flag");

endmodule

`default_nettype wire

// ===== rtl/signed_q16_16_divider.sv =====
// Signed Q16.16 divider: a pipelined chain of restoring shift-subtract cells.
// Depends on sqd_pkg, sqd_in_if, sqd_out_if, sqd_prep, sqd_cell and sqd_post.
//
// Usage:
//   in_i carries dividend and divisor, two's complement Q16.16; out_o returns
//   the Q16.16 quotient truncated toward zero, wrapped to 32 bits, with the
//   divide_by_zero and overflow flags. Each channel moves one item per
//   transfer, at a clock edge where valid and ready are both high.
//   From an operand transfer to the earliest transfer of its result on out_o, an
//   item passes one entry stage, 48 cells that each settle one quotient bit,
//   and the output register. An operand pair is taken every cycle the chain runs.
//   A zero divisor gives an all-ones magnitude (quotient -1 as raw bits, or
//   1 for a negative dividend) with both flags set.
//   When the receiver stalls, one more result is caught in a skid register;
//   after that the whole chain holds and in_i.ready drops until the output
//   is taken. in_i.ready comes straight from a register, never from out_o.ready.
//   Reset, asynchronous and active low, empties the chain; no result is
//   pending afterward and in_i.ready is high as soon as reset ends.
`default_nettype none

module signed_q16_16_divider
  import sqd_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  sqd_in_if.sink    in_i,
  sqd_out_if.source out_o
);

  sqd_stage_t chain [QuotW+1];
  logic       en;

  // Sign and magnitude entry stage.
  sqd_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .in_i    (in_i),
    .stage_o (chain[0])
  );

  // One cell per kept quotient bit, most significant first.
  for (genvar k = 0; k < QuotW; k++) begin : g_cell
    sqd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  // Sign, overflow and output buffering.
  sqd_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (chain[QuotW]),
    .en_o    (en),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
